// File: design/assert_macros.svh
// Assertion helpers for the replay ring. Every check is clocked on i_clk
// and held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/uirr_pkg.sv
`timescale 1ns / 1ps

package uirr_pkg;

    // Ring geometry.
    localparam int CAPACITY     = 32;
    localparam int PAYLOAD_BITS = 64;
    localparam int IDX_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    // Field widths on the streams.
    localparam int SEQ_W       = 32;
    localparam int PAY_W       = 64;
    localparam int CNT_OUT_W   = 6;
    localparam int S_TDATA_W   = 96;
    localparam int M_TDATA_W   = 176;

    // One stored entry: sequence number above the payload.
    localparam int ENT_W       = SEQ_W + PAYLOAD_BITS;

    // Request codes on the input side.
    typedef enum logic [1:0] {
        REQ_APPLY = 2'd0,
        REQ_RECON = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    // Result kinds on the output side.
    typedef enum logic [1:0] {
        KIND_RECEIPT = 2'd0,
        KIND_ENTRY   = 2'd1,
        KIND_DONE    = 2'd2
    } t_kind;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_CLEAR,
        S_PRUNE_RD,
        S_PRUNE_CMP,
        S_REP_RD,
        S_REP_EMIT,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture_apply;
        logic capture_recon;
        logic apply;
        logic clear;
        logic pop;
        logic rd_en;
        logic emit_entry;
        logic emit_done;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic ring_empty;
        logic seq_le_ack;
        logic rep_end;
    } t_sts;

endpackage

// File: design/unacked_input_replay_ring.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Ring of unacknowledged inputs for client-side prediction.
// Input stream s_axis: tuser carries the request (apply, reconcile, clear),
// tdata the payload and the acknowledged sequence number. Output stream
// m_axis: tuser carries the result kind, tlast marks the final result of a
// request, tdata the sequence number, entry payload, replay count, pending
// count, next sequence number and last acknowledged number.
// The single config bit enables replay of pending entries on reconcile.
// Apply and clear each pass from idle through their own state, which
// loads the result into the output register once it is free. A reconcile
// reads the one read port of the entry memory once for every prune
// compare and every replay.
// A new request is taken while the previous result still sits in the
// output register; when the receiver stalls, processing waits at the next
// result and the input side stops after one held request.
// Reset empties the ring and sets the next sequence number to 1 at once;
// the entry memory is not cleared, since only held entries are read.

module unacked_input_replay_ring (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // payload [63:0], acknowledged sequence number [95:64]
    input  logic [uirr_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // req_type [1:0]
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // seq [31:0], entry_payload [95:32], replay_count [101:96],
    // pending [107:102], next_seq_out [139:108], last_ack_out [171:140]
    output logic [uirr_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // kind [1:0]
    output logic [1:0]                        m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata
);
    import uirr_pkg::*;

    t_cmd                 cmd;
    t_sts                 sts;
    t_kind                kind;
    logic [SEQ_W-1:0]     seq;
    logic [PAY_W-1:0]     entry_payload;
    logic [CNT_OUT_W-1:0] replay_count;
    logic [CNT_OUT_W-1:0] pending;
    logic [SEQ_W-1:0]     next_num;
    logic [SEQ_W-1:0]     last_ack;
    logic                 out_entry;
    logic                 out_done;

    // Sequencer for the request steps.
    uirr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_req   (t_req'(s_axis_tuser)),
        .o_ready (s_axis_tready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // Ring storage, counters and output register.
    uirr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_payload       (s_axis_tdata[PAY_W-1:0]),
        .i_ack_num       (s_axis_tdata[PAY_W +: SEQ_W]),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_kind          (kind),
        .o_seq           (seq),
        .o_entry_payload (entry_payload),
        .o_replay_count  (replay_count),
        .o_pending       (pending),
        .o_next_num      (next_num),
        .o_last_ack      (last_ack),
        .o_last          (m_axis_tlast)
    );

    // Pack the result fields onto the output stream.
    assign m_axis_tuser = kind;
    assign m_axis_tdata = {4'b0000, last_ack, next_num, pending, replay_count,
                           entry_payload, seq};

    // Kinds of the result on offer, for the checks below.
    assign out_entry = m_axis_tvalid && (kind == KIND_ENTRY);
    assign out_done  = m_axis_tvalid && (kind == KIND_DONE);

    // Replayed entries are never the final result of a request.
    `ASSERT_IMPLY(a_entry_not_last, out_entry, !m_axis_tlast, "replayed entry marked last")
    // The ring never reports more entries than it holds.
    `ASSERT_IMPLY(a_pending_bound, m_axis_tvalid, pending <= CNT_OUT_W'(CAPACITY), "pending too big")
    // A done result replays at most the entries still held.
    `ASSERT_IMPLY(a_replay_bound, out_done, replay_count <= pending, "replay count above pending")

endmodule

// File: design/uirr_ctrl.sv
`timescale 1ns / 1ps

module uirr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  uirr_pkg::t_req i_req,
    output logic           o_ready,
    output uirr_pkg::t_cmd o_cmd,
    input  uirr_pkg::t_sts i_sts
);
    import uirr_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (i_req)
                        REQ_APPLY: begin
                            o_cmd.capture_apply = 1'b1;
                            n_state = S_APPLY;
                        end
                        REQ_RECON: begin
                            o_cmd.capture_recon = 1'b1;
                            n_state = S_PRUNE_RD;
                        end
                        REQ_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                        default: begin
                            // An unknown request is taken and dropped.
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_APPLY: begin
                if (i_sts.out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (i_sts.out_free) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PRUNE_RD: begin
                if (i_sts.ring_empty) begin
                    n_state = S_REP_RD;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_PRUNE_CMP;
                end
            end
            S_PRUNE_CMP: begin
                if (i_sts.seq_le_ack) begin
                    o_cmd.pop = 1'b1;
                    n_state = S_PRUNE_RD;
                end else begin
                    n_state = S_REP_RD;
                end
            end
            S_REP_RD: begin
                if (i_sts.rep_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_REP_EMIT;
                end
            end
            S_REP_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_entry = 1'b1;
                    n_state = S_REP_RD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/uirr_dp.sv
`timescale 1ns / 1ps

module uirr_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_wdata,
    input  logic [uirr_pkg::PAY_W-1:0]       i_payload,
    input  logic [uirr_pkg::SEQ_W-1:0]       i_ack_num,
    input  uirr_pkg::t_cmd                   i_cmd,
    output uirr_pkg::t_sts                   o_sts,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output uirr_pkg::t_kind                  o_kind,
    output logic [uirr_pkg::SEQ_W-1:0]       o_seq,
    output logic [uirr_pkg::PAY_W-1:0]       o_entry_payload,
    output logic [uirr_pkg::CNT_OUT_W-1:0]   o_replay_count,
    output logic [uirr_pkg::CNT_OUT_W-1:0]   o_pending,
    output logic [uirr_pkg::SEQ_W-1:0]       o_next_num,
    output logic [uirr_pkg::SEQ_W-1:0]       o_last_ack,
    output logic                             o_last
);
    import uirr_pkg::*;

    // Step a ring index forward with wrap.
    function automatic logic [IDX_W-1:0] f_inc(input logic [IDX_W-1:0] a);
        return (a == IDX_W'(CAPACITY - 1)) ? '0 : a + 1'b1;
    endfunction

    logic [ENT_W-1:0]        r_mem [CAPACITY];
    logic [ENT_W-1:0]        r_rdata;

    logic [IDX_W-1:0]        r_oldest, n_oldest;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [SEQ_W-1:0]        r_next, n_next;
    logic [SEQ_W-1:0]        r_ack, n_ack;
    logic [IDX_W-1:0]        r_rp, n_rp;
    logic [CNT_W-1:0]        r_k, n_k;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic                    r_en;
    logic                    r_valid;

    logic                    full;
    logic [CNT_W:0]          tail_sum;
    logic [CNT_W:0]          tail_wrap;
    logic [IDX_W-1:0]        wr_addr;
    logic                    wr_en;
    logic                    emit_any;
    logic [SEQ_W-1:0]        rd_seq;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    assign rd_seq = r_rdata[PAYLOAD_BITS +: SEQ_W];
    assign rd_pay = r_rdata[PAYLOAD_BITS-1:0];

    // Tail slot: oldest plus count, folded back into the ring.
    assign full      = (r_count == CNT_W'(CAPACITY));
    assign tail_sum  = (CNT_W+1)'(r_oldest) + (CNT_W+1)'(r_count);
    assign tail_wrap = (tail_sum >= (CNT_W+1)'(CAPACITY)) ?
                       tail_sum - (CNT_W+1)'(CAPACITY) : tail_sum;
    // A full ring overwrites its oldest slot, which is dropped.
    assign wr_addr   = full ? r_oldest : tail_wrap[IDX_W-1:0];

    assign emit_any = i_cmd.apply | i_cmd.clear | i_cmd.emit_entry | i_cmd.emit_done;

    // Next values of the ring state.
    always_comb begin
        n_oldest = r_oldest;
        n_count  = r_count;
        n_next   = r_next;
        n_ack    = r_ack;
        n_rp     = r_rp;
        n_k      = r_k;
        wr_en    = 1'b0;
        if (i_cmd.capture_recon) begin
            n_ack = i_ack_num;
            n_rp  = r_oldest;
            n_k   = '0;
        end
        if (i_cmd.apply) begin
            wr_en  = 1'b1;
            n_next = r_next + 1'b1;
            if (full) begin
                n_oldest = f_inc(r_oldest);
            end else begin
                n_count = r_count + 1'b1;
            end
        end
        if (i_cmd.clear) begin
            n_oldest = '0;
            n_count  = '0;
            n_next   = SEQ_W'(1);
            n_ack    = '0;
        end
        if (i_cmd.pop) begin
            n_oldest = f_inc(r_oldest);
            n_rp     = f_inc(r_rp);
            n_count  = r_count - 1'b1;
        end
        if (i_cmd.emit_entry) begin
            n_rp = f_inc(r_rp);
            n_k  = r_k + 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_count  <= '0;
            r_next   <= SEQ_W'(1);
            r_ack    <= '0;
            r_rp     <= '0;
            r_k      <= '0;
            r_en     <= 1'b1;
            r_valid  <= 1'b0;
        end else begin
            r_oldest <= n_oldest;
            r_count  <= n_count;
            r_next   <= n_next;
            r_ack    <= n_ack;
            r_rp     <= n_rp;
            r_k      <= n_k;
            if (i_cfg_we) begin
                r_en <= i_cfg_wdata;
            end
            if (emit_any) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload held for the apply step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_apply) begin
            r_pay <= i_payload[PAYLOAD_BITS-1:0];
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {r_next, r_pay};
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[r_rp];
        end
    end

    // Output register; the state fields show the values after the step.
    always_ff @(posedge i_clk) begin
        if (emit_any) begin
            o_pending  <= CNT_OUT_W'(n_count);
            o_next_num <= n_next;
            o_last_ack <= n_ack;
            if (i_cmd.apply) begin
                o_kind          <= KIND_RECEIPT;
                o_seq           <= r_next;
                o_entry_payload <= '0;
                o_replay_count  <= '0;
                o_last          <= 1'b1;
            end else if (i_cmd.emit_entry) begin
                o_kind          <= KIND_ENTRY;
                o_seq           <= rd_seq;
                o_entry_payload <= PAY_W'(rd_pay);
                o_replay_count  <= '0;
                o_last          <= 1'b0;
            end else if (i_cmd.emit_done) begin
                o_kind          <= KIND_DONE;
                o_seq           <= '0;
                o_entry_payload <= '0;
                o_replay_count  <= CNT_OUT_W'(r_k);
                o_last          <= 1'b1;
            end else begin
                o_kind          <= KIND_DONE;
                o_seq           <= '0;
                o_entry_payload <= '0;
                o_replay_count  <= '0;
                o_last          <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_valid;

    // Status back to the controller.
    always_comb begin
        o_sts.out_free   = !r_valid || i_out_ready;
        o_sts.ring_empty = (r_count == '0);
        o_sts.seq_le_ack = (rd_seq <= r_ack);
        o_sts.rep_end    = !r_en || (r_k == r_count);
    end

endmodule
